// ===== hdl/b2s_pkg.sv =====
package b2s_pkg;

	localparam int unsigned NumRegs = 6;
	localparam int unsigned AddrW = 6;

	localparam logic [31:0] IV [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};
	localparam logic [31:0] ParamBase = 32'h01010000;

	localparam logic [2:0] RegDlen = 3'd0;
	localparam logic [2:0] RegKlen = 3'd1;
	localparam logic [2:0] RegKey0 = 3'd2;
	localparam logic [2:0] RegKey1 = 3'd3;
	localparam logic [2:0] RegKey2 = 3'd4;
	localparam logic [2:0] RegKey3 = 3'd5;

	localparam logic OpAbsorb = 1'b0;
	localparam logic OpFinish = 1'b1;

	// message word schedule, one row per round
	localparam logic [3:0] SIGMA [10][16] = '{
		'{4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8,4'd9,4'd10,4'd11,4'd12,4'd13,4'd14,4'd15},
		'{4'd14,4'd10,4'd4,4'd8,4'd9,4'd15,4'd13,4'd6,4'd1,4'd12,4'd0,4'd2,4'd11,4'd7,4'd5,4'd3},
		'{4'd11,4'd8,4'd12,4'd0,4'd5,4'd2,4'd15,4'd13,4'd10,4'd14,4'd3,4'd6,4'd7,4'd1,4'd9,4'd4},
		'{4'd7,4'd9,4'd3,4'd1,4'd13,4'd12,4'd11,4'd14,4'd2,4'd6,4'd5,4'd10,4'd4,4'd0,4'd15,4'd8},
		'{4'd9,4'd0,4'd5,4'd7,4'd2,4'd4,4'd10,4'd15,4'd14,4'd1,4'd11,4'd12,4'd6,4'd8,4'd3,4'd13},
		'{4'd2,4'd12,4'd6,4'd10,4'd0,4'd11,4'd8,4'd3,4'd4,4'd13,4'd7,4'd5,4'd15,4'd14,4'd1,4'd9},
		'{4'd12,4'd5,4'd1,4'd15,4'd14,4'd13,4'd4,4'd10,4'd0,4'd7,4'd6,4'd3,4'd9,4'd2,4'd8,4'd11},
		'{4'd13,4'd11,4'd7,4'd14,4'd12,4'd1,4'd3,4'd9,4'd5,4'd0,4'd15,4'd4,4'd8,4'd6,4'd2,4'd10},
		'{4'd6,4'd15,4'd14,4'd9,4'd11,4'd3,4'd0,4'd8,4'd12,4'd2,4'd13,4'd7,4'd1,4'd4,4'd10,4'd5},
		'{4'd10,4'd2,4'd8,4'd4,4'd7,4'd6,4'd1,4'd5,4'd15,4'd11,4'd9,4'd14,4'd3,4'd12,4'd13,4'd0}
	};

	// working vector indices per column or diagonal step
	localparam logic [3:0] GA [8] = '{4'd0,4'd1,4'd2,4'd3,4'd0,4'd1,4'd2,4'd3};
	localparam logic [3:0] GB [8] = '{4'd4,4'd5,4'd6,4'd7,4'd5,4'd6,4'd7,4'd4};
	localparam logic [3:0] GC [8] = '{4'd8,4'd9,4'd10,4'd11,4'd10,4'd11,4'd8,4'd9};
	localparam logic [3:0] GD [8] = '{4'd12,4'd13,4'd14,4'd15,4'd15,4'd12,4'd13,4'd14};

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
	} g_quad_t;

endpackage

// ===== hdl/b2s_g_unit.sv =====
// one quarter-round mixing function, purely combinational
module b2s_g_unit (
	input  b2s_pkg::g_quad_t qin,
	input  logic [31:0]      x,
	input  logic [31:0]      y,
	output b2s_pkg::g_quad_t qout
);
	import b2s_pkg::*;

	logic [31:0] a1, d1, c1, b1, a2, d2, c2, b2, t0, t1, t2, t3;

	always_comb begin
		a1 = qin.a + qin.b + x;
		t0 = qin.d ^ a1;
		d1 = {t0[15:0], t0[31:16]};
		c1 = qin.c + d1;
		t1 = qin.b ^ c1;
		b1 = {t1[11:0], t1[31:12]};
		a2 = a1 + b1 + y;
		t2 = d1 ^ a2;
		d2 = {t2[7:0], t2[31:8]};
		c2 = c1 + d2;
		t3 = b1 ^ c2;
		b2 = {t3[6:0], t3[31:7]};
		qout = '{a: a2, b: b2, c: c2, d: d2};
	end

endmodule

// ===== hdl/blake2s_byte_stream_hash.sv =====
// BLAKE2s (RFC 7693) over a byte stream, keyed or unkeyed.
// Input channel: in_valid/in_stall with op and data_byte. op absorbs a byte
// (OpAbsorb) or finishes the message (OpFinish). Output channel:
// out_valid/out_stall with digest_byte and last_byte, one word per digest
// byte, little-endian per chain word; last_byte marks the final one.
// An absorb byte normally goes straight into the buffer, so bytes can follow back to back.
// A byte arriving on a full block first runs the compression (ten rounds
// of eight G steps, one G step per cycle on a single shared G unit), then
// the finalisation and the store of the held byte; only after that is the
// next word taken.
// A finish item pads and compresses, and the first digest byte is offered
// after the finalisation of that last block; then digest_length bytes
// follow, one per cycle while out_stall is low. A stall on the output holds
// the current digest byte; no further input is taken until the last digest
// byte has gone. The next word can be taken the cycle after that.
// The configuration port (APB-style, 64-bit data, registers at 8*i) should
// be written only while idle; new lengths and key take effect at the next
// message start. The key block, when a key is set, is compressed before the
// first message byte as the first full block.
// Reset clears the message state; the first item after reset opens a message.
module blake2s_byte_stream_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [b2s_pkg::AddrW-1:0] paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  digest_byte,
	output logic        last_byte
);
	import b2s_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_ROUND, S_FINAL, S_EMIT} state_t;

	state_t      state_q;
	logic [5:0]  dlen_cfg_q, klen_cfg_q, dlen_q;
	logic [63:0] key_q [4];
	logic [31:0] h_q [8];
	logic [31:0] v_q [16];
	logic [31:0] buf_q [16];
	logic [6:0]  fill_q;
	logic [63:0] cnt_q;
	logic        open_q;
	logic [3:0]  round_q;
	logic [2:0]  step_q;
	logic        is_fin_q;
	logic        pend_q;
	logic [7:0]  pend_byte_q;
	logic [4:0]  out_idx_q;

	logic [2:0]  reg_idx;
	logic        cfg_wr;
	g_quad_t     gin, gout;
	logic [31:0] mx, my;
	logic [3:0]  sx, sy;
	logic [5:0]  dl_cl, kl_cl;
	logic [31:0] hw;
	logic [31:0] h_init [8];
	logic [31:0] kblk [16];
	logic [31:0] pblk [16];

	assign pready = 1'b1;
	assign reg_idx = paddr[5:3];
	assign cfg_wr = psel && penable && pwrite;

	// register read back
	always_comb begin
		unique case (reg_idx)
			RegDlen: prdata = {58'd0, dlen_cfg_q};
			RegKlen: prdata = {58'd0, klen_cfg_q};
			RegKey0: prdata = key_q[0];
			RegKey1: prdata = key_q[1];
			RegKey2: prdata = key_q[2];
			RegKey3: prdata = key_q[3];
			default: prdata = 64'd0;
		endcase
	end

	// clamped lengths and opening chain for message start
	always_comb begin
		dl_cl = (dlen_cfg_q == 6'd0) ? 6'd1 : (dlen_cfg_q > 6'd32) ? 6'd32 : dlen_cfg_q;
		kl_cl = (klen_cfg_q > 6'd32) ? 6'd32 : klen_cfg_q;
		for (int i = 0; i < 8; i++) h_init[i] = IV[i];
		h_init[0] = IV[0] ^ ParamBase ^ {16'd0, 2'd0, kl_cl, 8'd0} ^ {26'd0, dl_cl};
	end

	// key block and zero-padded block, one word at a time
	always_comb begin
		for (int w = 0; w < 16; w++) begin
			for (int b = 0; b < 4; b++) begin
				kblk[w][8*b +: 8] = (4*w + b < kl_cl) ?
					key_q[w/2][32*(w%2) + 8*b +: 8] : 8'd0;
				pblk[w][8*b +: 8] = (4*w + b < fill_q) ? buf_q[w][8*b +: 8] : 8'd0;
			end
		end
	end

	// operand select for the shared G unit
	always_comb begin
		sx  = SIGMA[round_q][{step_q, 1'b0}];
		sy  = SIGMA[round_q][{step_q, 1'b1}];
		mx  = buf_q[sx];
		my  = buf_q[sy];
		gin = '{a: v_q[GA[step_q]], b: v_q[GB[step_q]],
			c: v_q[GC[step_q]], d: v_q[GD[step_q]]};
		hw  = h_q[out_idx_q[4:2]];
	end

	b2s_g_unit u_g (.qin(gin), .x(mx), .y(my), .qout(gout));

	assign in_stall    = (state_q != S_IDLE) || pend_q;
	assign out_valid   = (state_q == S_EMIT);
	assign digest_byte = hw[{out_idx_q[1:0], 3'd0} +: 8];
	assign last_byte   = ({1'b0, out_idx_q} + 6'd1 == dlen_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dlen_cfg_q <= 6'd32;
			klen_cfg_q <= 6'd0;
			for (int i = 0; i < 4; i++) key_q[i] <= 64'd0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				RegDlen: dlen_cfg_q <= pwdata[5:0];
				RegKlen: klen_cfg_q <= pwdata[5:0];
				RegKey0: key_q[0] <= pwdata;
				RegKey1: key_q[1] <= pwdata;
				RegKey2: key_q[2] <= pwdata;
				RegKey3: key_q[3] <= pwdata;
				default: ;
			endcase
		end
	end

	// block buffer, written by absorb, key load, padding and the held byte
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && !in_stall) begin
			if (!open_q && kl_cl != 6'd0) begin
				for (int w = 0; w < 16; w++) buf_q[w] <= kblk[w];
			end else if (op == OpFinish) begin
				for (int w = 0; w < 16; w++) buf_q[w] <= pblk[w];
			end else if (fill_q != 7'd64) begin
				buf_q[fill_q[5:2]][{fill_q[1:0], 3'd0} +: 8] <= data_byte;
			end
		end else if (state_q == S_IDLE && pend_q) begin
			buf_q[0][7:0] <= pend_byte_q;
		end
	end

	// sequencer and hash state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= 7'd0;
			cnt_q       <= 64'd0;
			open_q      <= 1'b0;
			round_q     <= 4'd0;
			step_q      <= 3'd0;
			is_fin_q    <= 1'b0;
			pend_q      <= 1'b0;
			pend_byte_q <= 8'd0;
			out_idx_q   <= 5'd0;
			dlen_q      <= 6'd0;
			for (int i = 0; i < 8; i++) h_q[i] <= 32'd0;
			for (int i = 0; i < 16; i++) v_q[i] <= 32'd0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (pend_q) begin
						// byte that arrived on a full block
						pend_q <= 1'b0;
						fill_q <= 7'd1;
					end else if (in_valid) begin
						logic [6:0]  f;
						logic [63:0] c;
						f = open_q ? fill_q : ((kl_cl != 6'd0) ? 7'd64 : 7'd0);
						c = open_q ? cnt_q : 64'd0;
						if (op == OpFinish) c = c + {57'd0, f};
						else if (f == 7'd64) c = c + 64'd64;
						if (!open_q) begin
							open_q <= 1'b1;
							dlen_q <= dl_cl;
							for (int i = 0; i < 8; i++) h_q[i] <= h_init[i];
						end
						cnt_q    <= c;
						is_fin_q <= (op == OpFinish);
						if (op == OpFinish) begin
							fill_q  <= 7'd64;
							state_q <= S_ROUND;
						end else if (f == 7'd64) begin
							pend_q      <= 1'b1;
							pend_byte_q <= data_byte;
							state_q     <= S_ROUND;
						end else begin
							fill_q <= f + 7'd1;
						end
						round_q <= 4'd0;
						step_q  <= 3'd0;
						// working vector load, using opened chain where just opened
						for (int i = 0; i < 8; i++)
							v_q[i] <= open_q ? h_q[i] : h_init[i];
						for (int i = 0; i < 4; i++)
							v_q[i+8] <= IV[i];
						v_q[12] <= IV[4] ^ c[31:0];
						v_q[13] <= IV[5] ^ c[63:32];
						v_q[14] <= (op == OpFinish) ? ~IV[6] : IV[6];
						v_q[15] <= IV[7];
					end
				end
				S_ROUND: begin
					v_q[GA[step_q]] <= gout.a;
					v_q[GB[step_q]] <= gout.b;
					v_q[GC[step_q]] <= gout.c;
					v_q[GD[step_q]] <= gout.d;
					step_q <= step_q + 3'd1;
					if (step_q == 3'd7) begin
						if (round_q == 4'd9) state_q <= S_FINAL;
						else round_q <= round_q + 4'd1;
					end
				end
				S_FINAL: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] ^ v_q[i] ^ v_q[i+8];
					out_idx_q <= 5'd0;
					if (is_fin_q) state_q <= S_EMIT;
					else state_q <= S_IDLE;
				end
				S_EMIT: begin
					if (!out_stall) begin
						if (last_byte) begin
							state_q <= S_IDLE;
							open_q  <= 1'b0;
							fill_q  <= 7'd0;
						end else begin
							out_idx_q <= out_idx_q + 5'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
